@@ rtl/core/image_crc32_validator_core_defines.svh @@
// ----------------------------------------------------------------------------
// Image CRC-32 validator: assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef IMAGE_CRC32_VALIDATOR_CORE_DEFINES_SVH
`define IMAGE_CRC32_VALIDATOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, held off during reset
`define ICRC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("icrc check failed");

// next-cycle implication, sampled on clk, held off during reset
`define ICRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("icrc check failed");

`endif

@@ rtl/core/icrc_pkg.sv @@
// ----------------------------------------------------------------------------
// Image CRC-32 validator package
// Shared types, codes and the byte-wide CRC update.
// ----------------------------------------------------------------------------
package icrc_pkg;

  localparam int unsigned CRC_W    = 32;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned ICNT_W   = 16;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
  localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFFFFFF;
  localparam logic [CRC_W-1:0] WS_LIMIT_RST = 32'd16777216;
  localparam logic [CRC_W-1:0] MAJOR_VER_OK = 32'd1;

  localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_MAGIC   = 3'd1;
  localparam logic [STAT_W-1:0] ST_TOO_LARGE   = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_VERSION = 3'd3;
  localparam logic [STAT_W-1:0] ST_WS_LARGE    = 3'd4;
  localparam logic [STAT_W-1:0] ST_NO_INSTR    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_MAGIC    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_MAGIC = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAJOR_VERSION  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STORED_CRC     = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WS_BYTES       = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WS_LIMIT       = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INSTR_COUNT    = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BYTES   = 8'd7;

  typedef struct packed {
    logic                checksum_ok;
    logic [STAT_W-1:0]   status;
    logic [CRC_W-1:0]    computed_crc;
  } result_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [7:0]       data);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/core/image_crc32_validator_core.sv @@
// A last byte's result is registered and valid at the output in the cycle after it is accepted,
// or, while an earlier result is held there, in the cycle after that result is taken.
// Throughput: one byte per cycle while in_tready is high; the unrolled CRC update is combinational.
// in_tready drops only while both the output register and the skid stage hold results.
// Reset: synchronous, active low; CRC returns to all ones, valid flags and header registers to their defaults.
// ----------------------------------------------------------------------------
// Image CRC-32 validator core
// Streams image bytes through a reflected CRC-32 and reports header status.
// ----------------------------------------------------------------------------
module image_crc32_validator_core #(
  parameter int unsigned MAX_IMAGE_BYTES   = 32'd16777216,
  parameter int unsigned HEADER_BYTES      = 32'd256,
  parameter int unsigned INSTRUCTION_BYTES = 32'd64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] data_byte
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] computed_crc, [34:32] status, [35] checksum_ok, [39:36] zero
  output logic [icrc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [icrc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [icrc_pkg::CFG_DAT_W-1:0]      cfg_data
);

  logic                        in_accept;
  logic                        skid_full;
  logic [icrc_pkg::CRC_W-1:0]  crc_final;
  icrc_pkg::result_t           result;
  icrc_pkg::result_t           out_res;

  assign in_tready = ~skid_full;
  assign in_accept = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;

  icrc_crc_unit u_crc (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .crc_final (crc_final)
  );

  icrc_hdr_check #(
    .MAX_IMAGE_BYTES   (MAX_IMAGE_BYTES),
    .HEADER_BYTES      (HEADER_BYTES),
    .INSTRUCTION_BYTES (INSTRUCTION_BYTES)
  ) u_hdr (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .crc_final (crc_final),
    .result    (result)
  );

  icrc_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept & in_tlast),
    .push_data (result),
    .pop       (out_tready),
    .out_vld   (out_tvalid),
    .out_data  (out_res),
    .skid_full (skid_full)
  );

  assign out_tdata = {4'd0, out_res.checksum_ok, out_res.status, out_res.computed_crc};

endmodule

@@ rtl/core/icrc_crc_unit.sv @@
// ----------------------------------------------------------------------------
// CRC unit
// Running CRC register with an eight-bit unrolled update per byte.
// ----------------------------------------------------------------------------
module icrc_crc_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [7:0]                    data_byte,
  input  logic                          last_byte,
  output logic [icrc_pkg::CRC_W-1:0]    crc_final
);

  logic [icrc_pkg::CRC_W-1:0] crc_r;
  logic [icrc_pkg::CRC_W-1:0] crc_upd;
  logic [icrc_pkg::CRC_W-1:0] crc_nxt;

  always_comb begin
    crc_upd   = icrc_pkg::crc_byte(crc_r, data_byte);
    crc_final = crc_upd ^ icrc_pkg::CRC_ONES;
    crc_nxt   = crc_r;
    if (accept) begin
      crc_nxt = last_byte ? icrc_pkg::CRC_ONES : crc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= icrc_pkg::CRC_ONES;
    end else begin
      crc_r <= crc_nxt;
    end
  end

endmodule

@@ rtl/core/icrc_hdr_check.sv @@
// ----------------------------------------------------------------------------
// Header check
// Holds the header registers and derives status and checksum match.
// ----------------------------------------------------------------------------
module icrc_hdr_check #(
  parameter int unsigned MAX_IMAGE_BYTES   = 32'd16777216,
  parameter int unsigned HEADER_BYTES      = 32'd256,
  parameter int unsigned INSTRUCTION_BYTES = 32'd64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [icrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [icrc_pkg::CFG_DAT_W-1:0]   cfg_data,
  input  logic [icrc_pkg::CRC_W-1:0]       crc_final,
  output icrc_pkg::result_t                result
);

  localparam int unsigned TOT_W = 34;
  localparam int unsigned IB_W  = $clog2(INSTRUCTION_BYTES + 1);
  localparam int unsigned PRD_W = icrc_pkg::ICNT_W + IB_W;

  logic [31:0]                     image_magic_r;
  logic [31:0]                     expected_magic_r;
  logic [31:0]                     major_version_r;
  logic [31:0]                     stored_crc_r;
  logic [31:0]                     ws_bytes_r;
  logic [31:0]                     ws_limit_r;
  logic [icrc_pkg::ICNT_W-1:0]     instr_count_r;
  logic [31:0]                     weight_bytes_r;

  logic [PRD_W-1:0]                instr_total;
  logic [TOT_W-1:0]                image_total;
  logic [icrc_pkg::STAT_W-1:0]     status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_magic_r    <= '0;
      expected_magic_r <= '0;
      major_version_r  <= '0;
      stored_crc_r     <= '0;
      ws_bytes_r       <= '0;
      ws_limit_r       <= icrc_pkg::WS_LIMIT_RST;
      instr_count_r    <= '0;
      weight_bytes_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        icrc_pkg::REG_IMAGE_MAGIC:    image_magic_r    <= cfg_data;
        icrc_pkg::REG_EXPECTED_MAGIC: expected_magic_r <= cfg_data;
        icrc_pkg::REG_MAJOR_VERSION:  major_version_r  <= cfg_data;
        icrc_pkg::REG_STORED_CRC:     stored_crc_r     <= cfg_data;
        icrc_pkg::REG_WS_BYTES:       ws_bytes_r       <= cfg_data;
        icrc_pkg::REG_WS_LIMIT:       ws_limit_r       <= cfg_data;
        icrc_pkg::REG_INSTR_COUNT:    instr_count_r    <= cfg_data[icrc_pkg::ICNT_W-1:0];
        icrc_pkg::REG_WEIGHT_BYTES:   weight_bytes_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    instr_total = PRD_W'(instr_count_r) * PRD_W'(INSTRUCTION_BYTES);
    image_total = TOT_W'(HEADER_BYTES) + TOT_W'(instr_total) + TOT_W'(weight_bytes_r);
    if (image_magic_r != expected_magic_r) begin
      status = icrc_pkg::ST_BAD_MAGIC;
    end else if (image_total > TOT_W'(MAX_IMAGE_BYTES)) begin
      status = icrc_pkg::ST_TOO_LARGE;
    end else if (major_version_r != icrc_pkg::MAJOR_VER_OK) begin
      status = icrc_pkg::ST_BAD_VERSION;
    end else if (ws_bytes_r > ws_limit_r) begin
      status = icrc_pkg::ST_WS_LARGE;
    end else if (instr_count_r == '0) begin
      status = icrc_pkg::ST_NO_INSTR;
    end else begin
      status = icrc_pkg::ST_OK;
    end
    result.computed_crc = crc_final;
    result.status       = status;
    result.checksum_ok  = (crc_final == stored_crc_r);
  end

endmodule

@@ rtl/core/icrc_out_buf.sv @@
// ----------------------------------------------------------------------------
// Result buffer
// Output register with a skid stage behind it.
// ----------------------------------------------------------------------------
module icrc_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  icrc_pkg::result_t  push_data,
  input  logic               pop,
  output logic               out_vld,
  output icrc_pkg::result_t  out_data,
  output logic               skid_full
);

  logic               out_vld_r;
  logic               out_vld_nxt;
  logic               skid_vld_r;
  logic               skid_vld_nxt;
  icrc_pkg::result_t  out_data_r;
  icrc_pkg::result_t  out_data_nxt;
  icrc_pkg::result_t  skid_data_r;
  icrc_pkg::result_t  skid_data_nxt;
  logic               take;

  always_comb begin
    take          = out_vld_r & pop;
    out_vld_nxt   = out_vld_r;
    skid_vld_nxt  = skid_vld_r;
    out_data_nxt  = out_data_r;
    skid_data_nxt = skid_data_r;
    if (push) begin
      if (!out_vld_r || take) begin
        out_vld_nxt  = 1'b1;
        out_data_nxt = push_data;
      end else begin
        skid_vld_nxt  = 1'b1;
        skid_data_nxt = push_data;
      end
    end else if (take) begin
      out_vld_nxt  = skid_vld_r;
      out_data_nxt = skid_data_r;
      skid_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_vld   = out_vld_r;
  assign out_data  = out_data_r;
  assign skid_full = skid_vld_r;

endmodule

@@ rtl/core/icrc_checker.sv @@
// ----------------------------------------------------------------------------
// Port checker
// Watches the validator core's ports; attached by bind.
// ----------------------------------------------------------------------------
`include "image_crc32_validator_core_defines.svh"

module icrc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                in_tlast,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [icrc_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  `ICRC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `ICRC_ASSERT_NOW(a_status_range, out_tvalid, out_tdata[34:32] <= icrc_pkg::ST_NO_INSTR)
  `ICRC_ASSERT_NOW(a_pad_zero, out_tvalid, out_tdata[39:36] == 4'd0)
  `ICRC_ASSERT_NEXT(a_last_gives_result, in_tvalid && in_tready && in_tlast, out_tvalid)

endmodule

bind image_crc32_validator_core icrc_checker u_icrc_checker (.*);
